FILE: rtl/sorted_table_insert_delete_unit_macros.svh
// Assertion macros used by the checker of the sorted table unit.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef SORTED_TABLE_INSERT_DELETE_UNIT_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define STID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define STID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/stid_pkg.sv
// Shared types and constants for the sorted table insert/delete unit.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package stid_pkg;

  localparam int STID_CAPACITY   = 16;
  localparam int STID_VALUE_BITS = 32;

  // Request opcodes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic do_insert;
    logic do_delete;
  } stid_op_t;

endpackage

FILE: rtl/stid_cell.sv
// One slot of the sorted row: holds an entry and its valid flag and trades
// data with its neighbors on insert (shift up) and delete (shift down).
// Depends on stid_pkg.
`timescale 1ns / 1ps

module stid_cell #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  stid_pkg::stid_op_t op,
  input  logic [W-1:0]      key,
  input  logic              left_valid,
  input  logic              left_greater,
  input  logic [W-1:0]      left_entry,
  input  logic              right_valid,
  input  logic [W-1:0]      right_entry,
  output logic              valid,
  output logic              greater,
  output logic              match,
  output logic [W-1:0]      entry
);
  import stid_pkg::*;

  logic at_or_above;
  logic ins_load;

  assign greater     = valid && ($signed(entry) > $signed(key));
  assign match       = valid && (entry == key);
  assign at_or_above = greater || match;

  // Load on insert where the new key or a displaced entry lands.
  assign ins_load = op.do_insert && left_valid && (greater || !valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.do_insert) begin
      valid <= left_valid;
    end else if (op.do_delete && at_or_above) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_load) begin
      entry <= left_greater ? left_entry : key;
    end else if (op.do_delete && at_or_above) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: rtl/sorted_table_insert_delete_unit.sv
// Sorted table insert/delete unit.
//
// Request channel (req_valid / req_stall) carries mode and value: mode
// MODE_INSERT places value after any equal entries, MODE_DELETE removes the
// first entry equal to value. Each request gives one response on the
// rsp_valid / rsp_stall channel: status (done, full, not found), entry_count,
// is_empty, and the smallest and largest values held (zero when empty).
//
// The table is a row of CAPACITY compare-and-shift cells; every cell decides
// locally in the cycle of the transfer, and the cells register the update.
// The response is formed in the following cycle (state S_RESULT), from the
// row's lowest cell and its last valid cell, and registered onto the outputs.
// No request is taken while a response is being formed in S_RESULT;
// a new request is taken in the same cycle the previous response transfers.
// While rsp_stall holds, the response stays put and req_stall is high.
// Reset (rst, synchronous) empties the table and drops any pending response.
// Values compare as two's complement numbers min(VALUE_BITS, 32) bits wide.
`timescale 1ns / 1ps

module sorted_table_insert_delete_unit #(
  parameter int CAPACITY   = stid_pkg::STID_CAPACITY,
  parameter int VALUE_BITS = stid_pkg::STID_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        mode,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [4:0]  entry_count,
  output logic        is_empty,
  output logic [31:0] smallest,
  output logic [31:0] largest
);
  import stid_pkg::*;

  localparam int EW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic          state;
  logic          accept;
  logic [EW-1:0] key;
  stid_op_t      op;
  logic          full;
  logic          found;
  logic [1:0]    st_pending;
  logic [CW-1:0] held_count;

  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_greater;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_last;
  logic [EW-1:0]       cell_entry [CAPACITY];
  logic [EW-1:0]       largest_sel;

  assign req_stall = (state == S_RESULT) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign key       = value[EW-1:0];
  assign full      = cell_valid[CAPACITY-1];
  assign found     = |cell_match;

  assign op.do_insert = accept && (mode == MODE_INSERT) && !full;
  assign op.do_delete = accept && (mode == MODE_DELETE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          lv, lg, rv;
    logic [EW-1:0] le, re;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign le = '0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign lg = cell_greater[i-1];
      assign le = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign rv = 1'b0;
      assign re = '0;
      assign cell_last[i] = cell_valid[i];
    end else begin : g_below
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end

    stid_cell #(.W(EW)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .key          (key),
      .left_valid   (lv),
      .left_greater (lg),
      .left_entry   (le),
      .right_valid  (rv),
      .right_entry  (re),
      .valid        (cell_valid[i]),
      .greater      (cell_greater[i]),
      .match        (cell_match[i]),
      .entry        (cell_entry[i])
    );
  end

  // Pick the last valid cell; at most one cell_last bit is set.
  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_last[i]) begin
        largest_sel = largest_sel | cell_entry[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      held_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
          if (accept) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (op.do_insert) begin
        held_count <= held_count + CW'(1);
      end else if (op.do_delete) begin
        held_count <= held_count - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      priority if (mode == MODE_INSERT && full) begin
        st_pending <= ST_FULL;
      end else if (mode == MODE_DELETE && !found) begin
        st_pending <= ST_MISSING;
      end else begin
        st_pending <= ST_DONE;
      end
    end
    if (state == S_RESULT) begin
      status      <= st_pending;
      entry_count <= 5'(held_count);
      is_empty    <= !cell_valid[0];
      smallest    <= cell_valid[0] ? 32'($signed(cell_entry[0])) : 32'd0;
      largest     <= 32'($signed(largest_sel));
    end
  end

endmodule

FILE: rtl/stid_checker.sv
// Port-level checker for the sorted table unit, bound to the top level.
// Depends on sorted_table_insert_delete_unit_macros.svh.
`timescale 1ns / 1ps
`include "sorted_table_insert_delete_unit_macros.svh"

module stid_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic [4:0]  entry_count,
  input logic        is_empty,
  input logic [31:0] smallest,
  input logic [31:0] largest
);

  property p_rsp_hold;
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count) &&
      $stable(smallest) && $stable(largest);
  endproperty

  property p_rsp_timing;
    req_valid && !req_stall |=> !rsp_valid ##1 rsp_valid;
  endproperty

  property p_empty_fields;
    rsp_valid && is_empty |-> entry_count == 5'd0 && smallest == 32'd0 && largest == 32'd0;
  endproperty

  property p_ordered;
    rsp_valid && !is_empty |-> $signed(smallest) <= $signed(largest);
  endproperty

  // A stalled response holds.
  `STID_ASSERT(a_rsp_hold, p_rsp_hold, "response changed while stalled")

  // Every request transfer yields its response, formed in the S_RESULT state.
  `STID_ASSERT(a_rsp_timing, p_rsp_timing, "response not produced two cycles after request")

  // An empty table reports zero entries and zero bounds.
  `STID_ASSERT(a_empty_fields, p_empty_fields, "empty response with nonzero fields")

  // The reported smallest value is not above the reported largest value.
  `STID_ASSERT(a_ordered, p_ordered, "smallest above largest")

endmodule

bind sorted_table_insert_delete_unit stid_checker u_stid_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking bench for sorted_table_insert_delete_unit: directed rows, then random
// insert/delete traffic with random idling on both channels, scored by a local predictor.
// Depends on stid_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
  import stid_pkg::*;

  localparam logic [31:0] VMIN = 32'h8000_0000;
  localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic        empty;
    logic [31:0] lo;
    logic [31:0] hi;
  } table_result_t;

  typedef struct packed {
    logic          op;
    logic [31:0]   val;
    logic          typed;
    table_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        mode = MODE_INSERT;
  logic [31:0] value = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic [31:0] smallest;
  logic [31:0] largest;

  // predictor state: ascending values and how many are held
  logic [31:0]   held_values [STID_CAPACITY];
  int            held_total = 0;
  table_result_t results_due [$];
  table_result_t oldest_due;
  bit            calm = 1'b0;
  int            mismatches = 0;
  int            n_inserts = 0;
  int            n_deletes = 0;
  int            n_full = 0;
  int            n_missing = 0;
  int            n_empty = 0;
  stim_row_t     plan [25];

  sorted_table_insert_delete_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .smallest    (smallest),
    .largest     (largest)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("timeout: %0d responses still outstanding", results_due.size());
    $display("FAILURE");
    $finish;
  end

  // Apply one operation to the local table and return the result it should give.
  function automatic table_result_t apply_op(input logic op, input logic [31:0] v);
    table_result_t r;
    int pos;
    r.status = ST_DONE;
    pos = 0;
    if (op == MODE_INSERT) begin
      if (held_total >= STID_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // equal values stay ahead of the new one
        while (pos < held_total && !($signed(held_values[pos]) > $signed(v))) pos++;
        for (int i = held_total; i > pos; i--) held_values[i] = held_values[i - 1];
        held_values[pos] = v;
        held_total++;
      end
    end else begin
      while (pos < held_total && held_values[pos] != v) pos++;
      if (pos >= held_total) begin
        r.status = ST_MISSING;
      end else begin
        for (int i = pos; i + 1 < held_total; i++) held_values[i] = held_values[i + 1];
        held_total--;
      end
    end
    r.count = 5'(held_total);
    r.empty = (held_total == 0);
    r.lo = r.empty ? 32'd0 : held_values[0];
    r.hi = r.empty ? 32'd0 : held_values[held_total - 1];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return $urandom_range(0, 8) - 32'd4;
    if (k < 55) begin
      case ($urandom_range(0, 3))
        0: return VMIN;
        1: return VMAX;
        2: return VMIN + 32'd1;
        default: return VMAX - 32'd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Present one request, hold it until the transfer, then log what it should return.
  task automatic send_item(input logic op, input logic [31:0] v, input logic typed,
                           input table_result_t want);
    table_result_t r;
    while (!calm && $urandom_range(0, 99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    value     <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = apply_op(op, v);
    results_due.push_back(typed ? want : r);
    if (op == MODE_INSERT) n_inserts++; else n_deletes++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_MISSING) n_missing++;
    if (r.empty) n_empty++;
  endtask

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("response with nothing pending", {30'd0, status}, 32'd0);
      end else begin
        oldest_due = results_due.pop_front();
        if (status !== oldest_due.status)
          report_mismatch("status", {30'd0, status}, {30'd0, oldest_due.status});
        if (entry_count !== oldest_due.count)
          report_mismatch("entry_count", {27'd0, entry_count}, {27'd0, oldest_due.count});
        if (is_empty !== oldest_due.empty)
          report_mismatch("is_empty", {31'd0, is_empty}, {31'd0, oldest_due.empty});
        if (smallest !== oldest_due.lo) report_mismatch("smallest", smallest, oldest_due.lo);
        if (largest !== oldest_due.hi) report_mismatch("largest", largest, oldest_due.hi);
      end
    end
  end

  initial begin
    logic        op;
    logic [31:0] v;
    bit          filling;
    filling = 1'b1;
    plan = '{
      '{MODE_DELETE, 32'd0,        1'b1, '{ST_MISSING, 5'd0,  1'b1, 32'd0, 32'd0}},
      '{MODE_INSERT, 32'd0,        1'b1, '{ST_DONE,    5'd1,  1'b0, 32'd0, 32'd0}},
      '{MODE_INSERT, VMIN,         1'b1, '{ST_DONE,    5'd2,  1'b0, VMIN,  32'd0}},
      '{MODE_INSERT, VMAX,         1'b1, '{ST_DONE,    5'd3,  1'b0, VMIN,  VMAX}},
      '{MODE_INSERT, 32'd0,        1'b0, '0},
      '{MODE_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_INSERT, 32'd1,        1'b0, '0},
      '{MODE_INSERT, VMAX,         1'b0, '0},
      '{MODE_INSERT, VMIN,         1'b0, '0},
      '{MODE_INSERT, 32'h5555_5555, 1'b0, '0},
      '{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
      '{MODE_INSERT, 32'd7,        1'b0, '0},
      '{MODE_INSERT, 32'hFFFF_FFF9, 1'b0, '0},
      '{MODE_INSERT, 32'd0,        1'b0, '0},
      '{MODE_INSERT, 32'd100,      1'b0, '0},
      '{MODE_INSERT, 32'hFFFF_FF9C, 1'b0, '0},
      '{MODE_INSERT, 32'd3,        1'b0, '0},
      '{MODE_INSERT, 32'd42,       1'b1, '{ST_FULL,    5'd16, 1'b0, VMIN,  VMAX}},
      '{MODE_DELETE, 32'd12345,    1'b1, '{ST_MISSING, 5'd16, 1'b0, VMIN,  VMAX}},
      '{MODE_DELETE, 32'd0,        1'b0, '0},
      '{MODE_DELETE, VMIN,         1'b0, '0},
      '{MODE_DELETE, VMIN,         1'b0, '0},
      '{MODE_DELETE, VMAX,         1'b0, '0},
      '{MODE_DELETE, 32'h5555_5555, 1'b0, '0},
      '{MODE_DELETE, 32'hFFFF_FFFF, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].op, plan[i].val, plan[i].typed, plan[i].want);

    // swing between filling and draining so both full and empty get hit often
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 150 && n < 300);
      if (held_total >= STID_CAPACITY) filling = 1'b0;
      else if (held_total == 0) filling = 1'b1;
      op = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? MODE_INSERT : MODE_DELETE;
      if (op == MODE_DELETE && held_total > 0 && $urandom_range(0, 99) < 80)
        v = held_values[$urandom_range(0, held_total - 1)];
      else
        v = pick_value();
      send_item(op, v, 1'b0, '0);
    end
    req_valid <= 1'b0;
    calm      <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d inserts and %0d deletes with random idling on both channels",
             n_inserts, n_deletes);
    $display("saw %0d full refusals, %0d not-found deletes, %0d empty-table results",
             n_full, n_missing, n_empty);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
